>>> rtl/vot_pkg.sv
// shared types, tables and step functions for the velocity obstacle test
`default_nettype none

package vot_pkg;

    localparam int STEPS = 30;
    localparam logic [31:0] OVERLAP_HALF = 32'd1073673468;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [32:0] GAIN_INV = 33'sd652032874;
    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] HALF_S = 34'sd2147483648;

    localparam logic [31:0] ATAN_TAB [0:STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic [31:0]        z;
    } vec_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
    } rot_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [29:0] rt;
    } sq_t;

    typedef struct packed {
        logic signed [31:0] apx;
        logic signed [31:0] apy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
    } side_t;

    typedef struct packed {
        logic        apart;
        logic        bzero;
        logic [28:0] sn;
    } carry_a_t;

    typedef struct packed {
        logic        apart;
        logic        hzero;
        logic [31:0] bearing;
    } carry_h_t;

    typedef struct packed {
        logic neg1;
        logic neg2;
    } carry_d_t;

    function automatic vec_t atan_step(input vec_t a, input int sh);
        vec_t r;
        if (a.y > 33'sd0)
        begin
            r.x = a.x + (a.y >>> sh);
            r.y = a.y - (a.x >>> sh);
            r.z = a.z + ATAN_TAB[sh];
        end
        else
        begin
            r.x = a.x - (a.y >>> sh);
            r.y = a.y + (a.x >>> sh);
            r.z = a.z - ATAN_TAB[sh];
        end
        return r;
    endfunction

    function automatic rot_t rot_step(input rot_t a, input int sh);
        rot_t r;
        if (a.z >= 34'sd0)
        begin
            r.x = a.x - (a.y >>> sh);
            r.y = a.y + (a.x >>> sh);
            r.z = a.z - $signed({2'b00, ATAN_TAB[sh]});
        end
        else
        begin
            r.x = a.x + (a.y >>> sh);
            r.y = a.y - (a.x >>> sh);
            r.z = a.z + $signed({2'b00, ATAN_TAB[sh]});
        end
        return r;
    endfunction

    function automatic sq_t sqrt_step(input sq_t a, input logic [1:0] pair);
        sq_t r;
        logic [33:0] rem;
        logic [33:0] trial;
        rem = {a.rem[31:0], pair};
        trial = {2'b00, a.rt, 2'b01};
        if (rem >= trial)
        begin
            r.rem = rem - trial;
            r.rt = {a.rt[28:0], 1'b1};
        end
        else
        begin
            r.rem = rem;
            r.rt = {a.rt[28:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [4:0] msb_idx(input logic [31:0] m);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    function automatic rot_t rot_pre(input logic [31:0] a, output logic neg);
        rot_t r;
        logic signed [33:0] z;
        z = 34'($signed(a));
        neg = 1'b0;
        if (z > QUARTER)
        begin
            z = z - HALF_S;
            neg = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            z = z + HALF_S;
            neg = 1'b1;
        end
        r.x = GAIN_INV;
        r.y = 33'sd0;
        r.z = z;
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v,
                                                   input logic neg);
        logic signed [33:0] t;
        logic signed [15:0] r;
        t = (34'(v) + 34'sd32768) >>> 16;
        if (t > 34'sd16384)
        begin
            r = 16'sd16384;
        end
        else if (t < -34'sd16384)
        begin
            r = -16'sd16384;
        end
        else
        begin
            r = t[15:0];
        end
        if (neg)
        begin
            r = -r;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/velocity_obstacle_test.sv
// velocity obstacle test: fully pipelined bearing, half-angle and side cordics
// throughput: one item per cycle while the output is not stalled, set by the 30-stage cordic and square root pipes
// a stalled output freezes the pipe only once its last stage holds an item
// reset clears every stage valid bit and the output valid; data is not reset
`default_nettype none

module velocity_obstacle_test
    import vot_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic signed [31:0] robot_x,
    input  wire logic signed [31:0] robot_y,
    input  wire logic [30:0]        robot_radius,
    input  wire logic signed [31:0] obstacle_x,
    input  wire logic signed [31:0] obstacle_y,
    input  wire logic [30:0]        obstacle_radius,
    input  wire logic signed [31:0] obstacle_vel_x,
    input  wire logic signed [31:0] obstacle_vel_y,
    input  wire logic signed [31:0] candidate_vel_x,
    input  wire logic signed [31:0] candidate_vel_y,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic signed [31:0]      apex_x,
    output logic signed [31:0]      apex_y,
    output logic signed [15:0]      left_dir_x,
    output logic signed [15:0]      left_dir_y,
    output logic signed [15:0]      right_dir_x,
    output logic signed [15:0]      right_dir_y,
    output logic                    inside_res
);

    localparam int NST = 103;
    localparam int LAST = NST - 1;

    logic en;
    logic [NST-1:0] vld_reg;
    side_t side_reg [0:NST-1];

    logic out_vld_reg;
    logic signed [31:0] apx_reg, apy_reg;
    logic signed [15:0] olx_reg, oly_reg, orx_reg, ory_reg;
    logic oin_reg;

    // front end
    logic signed [32:0] dx0_reg, dy0_reg;
    logic [31:0] s0_reg;
    logic [31:0] ax1_reg, ay1_reg, s1_reg;
    logic negx1_reg, negy1_reg;
    logic [63:0] sqx2_reg, sqy2_reg, ss2_reg;
    logic [31:0] ax2_reg, ay2_reg, s2_reg;
    logic negx2_reg, negy2_reg;
    logic [4:0] msb2_reg;
    logic apart3_reg, negx3_reg, negy3_reg;
    logic [28:0] axn3_reg, ayn3_reg, sn3_reg;
    logic signed [32:0] nx4_reg, ny4_reg;
    logic [57:0] qx4_reg, qy4_reg, qs4_reg;
    logic apart4_reg;
    logic [28:0] sn4_reg;

    // bearing and square root pipes
    vec_t brg_reg [0:STEPS];
    sq_t sq_reg [0:STEPS];
    logic [59:0] v_reg [0:STEPS];
    carry_a_t ca_reg [0:STEPS];

    // half-angle pipe
    vec_t hlf_reg [0:STEPS];
    carry_h_t ch_reg [0:STEPS];

    // side direction pipes
    rot_t d1_reg [0:STEPS];
    rot_t d2_reg [0:STEPS];
    carry_d_t cd_reg [0:STEPS];

    // back end
    logic signed [15:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    logic signed [15:0] t1x_reg, t1y_reg, t2x_reg, t2y_reg;
    logic signed [31:0] p1_reg, p2_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic signed [15:0] lx2_reg, ly2_reg, rx2_reg, ry2_reg;
    logic signed [48:0] pl1_reg, pl2_reg, pr1_reg, pr2_reg;
    logic signed [15:0] lx3_reg, ly3_reg, rx3_reg, ry3_reg;
    logic in3_reg;

    logic [4:0] shr3, shl3;
    logic [31:0] axs3, ays3, ss3;
    logic [58:0] d2_5;
    logic [31:0] half_67;
    logic neg1_67, neg2_67;
    rot_t pre1_67, pre2_67;
    logic signed [32:0] crs_100;
    logic signed [49:0] il_102, ir_102;

    assign en = !(out_vld_reg && rsp_stall && vld_reg[LAST]);
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].apx <= obstacle_vel_x;
            side_reg[0].apy <= obstacle_vel_y;
            side_reg[0].rvx <= 33'(candidate_vel_x) - 33'(obstacle_vel_x);
            side_reg[0].rvy <= 33'(candidate_vel_y) - 33'(obstacle_vel_y);
        end
    end

    for (genvar k = 1; k < NST; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // normalising shift
    always_comb
    begin
        shr3 = (msb2_reg > 5'd28) ? msb2_reg - 5'd28 : 5'd0;
        shl3 = (msb2_reg < 5'd28) ? 5'd28 - msb2_reg : 5'd0;
        axs3 = (ax2_reg >> shr3) << shl3;
        ays3 = (ay2_reg >> shr3) << shl3;
        ss3 = (s2_reg >> shr3) << shl3;
        d2_5 = 59'(qx4_reg) + 59'(qy4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx0_reg <= 33'(obstacle_x) - 33'(robot_x);
            dy0_reg <= 33'(obstacle_y) - 33'(robot_y);
            s0_reg <= 32'(robot_radius) + 32'(obstacle_radius);

            negx1_reg <= dx0_reg[32];
            negy1_reg <= dy0_reg[32];
            ax1_reg <= dx0_reg[32] ? 32'(-dx0_reg) : dx0_reg[31:0];
            ay1_reg <= dy0_reg[32] ? 32'(-dy0_reg) : dy0_reg[31:0];
            s1_reg <= s0_reg;

            sqx2_reg <= 64'(ax1_reg) * 64'(ax1_reg);
            sqy2_reg <= 64'(ay1_reg) * 64'(ay1_reg);
            ss2_reg <= 64'(s1_reg) * 64'(s1_reg);
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            s2_reg <= s1_reg;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            msb2_reg <= msb_idx(ax1_reg | ay1_reg | s1_reg);

            apart3_reg <= (65'(sqx2_reg) + 65'(sqy2_reg)) > 65'(ss2_reg);
            axn3_reg <= axs3[28:0];
            ayn3_reg <= ays3[28:0];
            sn3_reg <= ss3[28:0];
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;

            nx4_reg <= negx3_reg ? -$signed(33'(axn3_reg)) : $signed(33'(axn3_reg));
            ny4_reg <= negy3_reg ? -$signed(33'(ayn3_reg)) : $signed(33'(ayn3_reg));
            qx4_reg <= 58'(axn3_reg) * 58'(axn3_reg);
            qy4_reg <= 58'(ayn3_reg) * 58'(ayn3_reg);
            qs4_reg <= 58'(sn3_reg) * 58'(sn3_reg);
            apart4_reg <= apart3_reg;
            sn4_reg <= sn3_reg;

            // bearing pre-rotation and square root operand
            if (nx4_reg < 33'sd0)
            begin
                brg_reg[0].x <= -nx4_reg;
                brg_reg[0].y <= -ny4_reg;
                brg_reg[0].z <= HALF_TURN;
            end
            else
            begin
                brg_reg[0].x <= nx4_reg;
                brg_reg[0].y <= ny4_reg;
                brg_reg[0].z <= 32'd0;
            end
            ca_reg[0].bzero <= (nx4_reg == 33'sd0) && (ny4_reg == 33'sd0);
            ca_reg[0].apart <= apart4_reg;
            ca_reg[0].sn <= sn4_reg;
            v_reg[0] <= (d2_5 > 59'(qs4_reg)) ? 60'(d2_5 - 59'(qs4_reg)) : 60'd0;
            sq_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_brg
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                brg_reg[k+1] <= atan_step(brg_reg[k], k);
                sq_reg[k+1] <= sqrt_step(sq_reg[k], v_reg[k][2*(STEPS-1-k)+1 -: 2]);
                v_reg[k+1] <= v_reg[k];
                ca_reg[k+1] <= ca_reg[k];
            end
        end
    end

    // half-angle: atan2(radius sum, tangent length)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hlf_reg[0].x <= $signed(33'(sq_reg[STEPS].rt));
            hlf_reg[0].y <= $signed(33'(ca_reg[STEPS].sn));
            hlf_reg[0].z <= 32'd0;
            ch_reg[0].apart <= ca_reg[STEPS].apart;
            ch_reg[0].hzero <= (sq_reg[STEPS].rt == 30'd0) && (ca_reg[STEPS].sn == 29'd0);
            ch_reg[0].bearing <= ca_reg[STEPS].bzero ? 32'd0 : brg_reg[STEPS].z;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_hlf
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hlf_reg[k+1] <= atan_step(hlf_reg[k], k);
                ch_reg[k+1] <= ch_reg[k];
            end
        end
    end

    always_comb
    begin
        if (!ch_reg[STEPS].apart)
        begin
            half_67 = OVERLAP_HALF;
        end
        else if (ch_reg[STEPS].hzero)
        begin
            half_67 = 32'd0;
        end
        else
        begin
            half_67 = hlf_reg[STEPS].z;
        end
        pre1_67 = rot_pre(ch_reg[STEPS].bearing - half_67, neg1_67);
        pre2_67 = rot_pre(ch_reg[STEPS].bearing + half_67, neg2_67);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg[0] <= pre1_67;
            d2_reg[0] <= pre2_67;
            cd_reg[0].neg1 <= neg1_67;
            cd_reg[0].neg2 <= neg2_67;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_dir
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_reg[k+1] <= rot_step(d1_reg[k], k);
                d2_reg[k+1] <= rot_step(d2_reg[k], k);
                cd_reg[k+1] <= cd_reg[k];
            end
        end
    end

    assign crs_100 = 33'(p1_reg) - 33'(p2_reg);
    assign il_102 = 50'(pl1_reg) - 50'(pl2_reg);
    assign ir_102 = 50'(pr1_reg) - 50'(pr2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1x_reg <= to_q14(d1_reg[STEPS].x, cd_reg[STEPS].neg1);
            s1y_reg <= to_q14(d1_reg[STEPS].y, cd_reg[STEPS].neg1);
            s2x_reg <= to_q14(d2_reg[STEPS].x, cd_reg[STEPS].neg2);
            s2y_reg <= to_q14(d2_reg[STEPS].y, cd_reg[STEPS].neg2);

            p1_reg <= 32'(s1x_reg) * 32'(s2y_reg);
            p2_reg <= 32'(s1y_reg) * 32'(s2x_reg);
            t1x_reg <= s1x_reg;
            t1y_reg <= s1y_reg;
            t2x_reg <= s2x_reg;
            t2y_reg <= s2y_reg;

            // order the sides, or drop both when they are not strictly ordered
            if (crs_100 > 33'sd0)
            begin
                rx_reg <= t1x_reg;
                ry_reg <= t1y_reg;
                lx_reg <= t2x_reg;
                ly_reg <= t2y_reg;
            end
            else if (crs_100 < 33'sd0)
            begin
                rx_reg <= t2x_reg;
                ry_reg <= t2y_reg;
                lx_reg <= t1x_reg;
                ly_reg <= t1y_reg;
            end
            else
            begin
                rx_reg <= '0;
                ry_reg <= '0;
                lx_reg <= '0;
                ly_reg <= '0;
            end

            pl1_reg <= 49'(lx_reg) * 49'(side_reg[100].rvy);
            pl2_reg <= 49'(ly_reg) * 49'(side_reg[100].rvx);
            pr1_reg <= 49'(rx_reg) * 49'(side_reg[100].rvy);
            pr2_reg <= 49'(ry_reg) * 49'(side_reg[100].rvx);
            lx2_reg <= lx_reg;
            ly2_reg <= ly_reg;
            rx2_reg <= rx_reg;
            ry2_reg <= ry_reg;

            in3_reg <= (il_102 < 50'sd0) && (ir_102 > 50'sd0);
            lx3_reg <= lx2_reg;
            ly3_reg <= ly2_reg;
            rx3_reg <= rx2_reg;
            ry3_reg <= ry2_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || !rsp_stall)
        begin
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || !rsp_stall)
        begin
            apx_reg <= side_reg[LAST].apx;
            apy_reg <= side_reg[LAST].apy;
            olx_reg <= lx3_reg;
            oly_reg <= ly3_reg;
            orx_reg <= rx3_reg;
            ory_reg <= ry3_reg;
            oin_reg <= in3_reg;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign apex_x = apx_reg;
    assign apex_y = apy_reg;
    assign left_dir_x = olx_reg;
    assign left_dir_y = oly_reg;
    assign right_dir_x = orx_reg;
    assign right_dir_y = ory_reg;
    assign inside_res = oin_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall && vld_reg[LAST]))
    else $error("input stalled without a waiting result");

    a_inside_sides: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && inside_res) |-> ((left_dir_x != 16'sd0 || left_dir_y != 16'sd0)
                                      && (right_dir_x != 16'sd0 || right_dir_y != 16'sd0)))
    else $error("inside reported with an empty side");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (left_dir_x <= 16'sd16384 && left_dir_x >= -16'sd16384
                       && right_dir_y <= 16'sd16384 && right_dir_y >= -16'sd16384))
    else $error("side direction out of range");

endmodule

`default_nettype wire
